// ===== design/qmf_pkg.sv =====
package qmf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_BITS  = 24;
  localparam int COEFF_FRAC  = COEFF_BITS - 1;
  localparam int PHASE_DEPTH = 23;
  localparam int PHASE_TAPS  = PHASE_DEPTH + 1;
  localparam int HALF_TAPS   = PHASE_TAPS;
  localparam int TAP_COUNT   = 2 * HALF_TAPS;
  localparam int PROD_BITS   = SAMPLE_BITS + COEFF_BITS;
  localparam int GROUP_SIZE  = 4;
  localparam int GROUPS      = PHASE_TAPS / GROUP_SIZE;
  localparam int GROUP_BITS  = PROD_BITS + 2;
  localparam int SUM_BITS    = PROD_BITS + 5;
  localparam int TOTAL_BITS  = SUM_BITS + 1;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int TAP_IDX_BITS = $clog2(HALF_TAPS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEFF_BITS-1:0]  coeff_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [GROUP_BITS-1:0]  group_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic signed [TOTAL_BITS-1:0]  total_t;
  typedef logic signed [OUT_BITS-1:0]    out_t;
  typedef sample_t [PHASE_TAPS-1:0]      window_t;

  // Load enables for the three stages inside each phase adder
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } qmf_ctl_t;

  // Half of the symmetric 48-tap prototype, doubled, Q0.23
  localparam coeff_t HALF_TAP_TABLE [HALF_TAPS] = '{
    -24'sd245,     -24'sd1544,    -24'sd942,     24'sd5053,
    24'sd4064,     -24'sd14310,   -24'sd8734,    24'sd34125,
    24'sd13142,    -24'sd70722,   -24'sd12686,   24'sd131538,
    -24'sd1026,    -24'sd225513,  24'sd41317,    24'sd364671,
    -24'sd130890,  -24'sd571939,  24'sd315571,   24'sd911439,
    -24'sd731426,  -24'sd1667393, 24'sd2215919,  24'sd7788681
  };

  function automatic coeff_t tap_coeff(input int unsigned k);
    int unsigned idx;
    idx = (k < HALF_TAPS) ? k : (TAP_COUNT - 1 - k);
    return HALF_TAP_TABLE[idx[TAP_IDX_BITS-1:0]];
  endfunction

endpackage

// ===== design/qmf_phase_sum.sv =====
module qmf_phase_sum import qmf_pkg::*; (
  input  logic     clk,
  input  qmf_ctl_t ctl,
  input  logic     odd_phase,
  input  window_t  window,
  output sum_t     phase_sum
);

  prod_t  prod_nxt  [PHASE_TAPS];
  prod_t  prod_r    [PHASE_TAPS];
  group_t group_nxt [GROUPS];
  group_t group_r   [GROUPS];
  sum_t   sum_nxt;
  sum_t   sum_r;

  // Stage 1: one constant multiply per tap
  always_comb begin
    for (int i = 0; i < PHASE_TAPS; i++) begin
      prod_nxt[i] = PROD_BITS'($signed(window[i]))
                  * PROD_BITS'($signed(tap_coeff(2 * i + int'(odd_phase))));
    end
  end

  // Stage 2: partial sums of four products
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        group_nxt[g] = group_nxt[g] + GROUP_BITS'(prod_r[g * GROUP_SIZE + j]);
      end
    end
  end

  // Stage 3: close the phase sum
  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_nxt = sum_nxt + SUM_BITS'(group_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      prod_r <= prod_nxt;
    end
    if (ctl.ld2) begin
      group_r <= group_nxt;
    end
    if (ctl.ld3) begin
      sum_r <= sum_nxt;
    end
  end

  assign phase_sum = sum_r;

endmodule

// ===== design/qmf_two_band_analysis.sv =====
// Two-band QMF analysis filter, 48-tap symmetric prototype. Each transfer on
// the input channel carries one pair of consecutive Q1.15 samples (earlier one
// first) and yields exactly one low-band/high-band pair on the result channel,
// both rounded half up to Q1.15 scale and saturated to 17 bits. One pair is
// accepted every cycle while in_stall is low; a result passes the multiply
// stage, two adder-tree stages, then the round/saturate output register.
// Both 23-deep sample histories are cleared by reset, so the first outputs
// see a zero past. Stall on the result side backs up stage by stage;
// bubbles in the pipe are squeezed out before in_stall rises.
module qmf_two_band_analysis import qmf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t in_first_sample,
  input  sample_t in_second_sample,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    out_low_band,
  output out_t    out_high_band
);

  localparam total_t ROUND_HALF = TOTAL_BITS'(64'sd1 <<< (COEFF_FRAC - 1));
  localparam total_t OUT_MAX    = TOTAL_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 1);
  localparam total_t OUT_MIN    = -OUT_MAX - TOTAL_BITS'(1);

  // Sample histories, newest at index 0
  sample_t even_hist_r [PHASE_DEPTH];
  sample_t odd_hist_r  [PHASE_DEPTH];

  logic v1_r, v2_r, v3_r;
  logic out_valid_r;
  out_t low_r, high_r;
  out_t low_nxt, high_nxt;

  logic ok1, ok2, ok3, ok4;
  logic in_accept;
  logic out_load;
  qmf_ctl_t ctl;

  window_t even_win, odd_win;
  sum_t    even_sum, odd_sum;

  // Backpressure: a stage may load when it is empty or its content moves on
  assign ok4       = !out_valid_r || !out_stall;
  assign ok3       = !v3_r || ok4;
  assign ok2       = !v2_r || ok3;
  assign ok1       = !v1_r || ok2;
  assign in_stall  = !ok1;
  assign in_accept = in_valid && ok1;
  assign out_load  = v3_r && ok4;

  assign ctl.ld1 = in_accept;
  assign ctl.ld2 = v1_r && ok2;
  assign ctl.ld3 = v2_r && ok3;

  // Even-phase taps see the odd-position samples, odd-phase taps the even ones
  always_comb begin
    even_win[0] = in_second_sample;
    odd_win[0]  = in_first_sample;
    for (int i = 1; i < PHASE_TAPS; i++) begin
      even_win[i] = odd_hist_r[i-1];
      odd_win[i]  = even_hist_r[i-1];
    end
  end

  qmf_phase_sum u_even (
    .clk       (clk),
    .ctl       (ctl),
    .odd_phase (1'b0),
    .window    (even_win),
    .phase_sum (even_sum)
  );

  qmf_phase_sum u_odd (
    .clk       (clk),
    .ctl       (ctl),
    .odd_phase (1'b1),
    .window    (odd_win),
    .phase_sum (odd_sum)
  );

  // Round half up to Q1.15, then clamp to the 17-bit range
  function automatic out_t round_sat(input total_t v);
    total_t t;
    total_t s;
    t = v + ROUND_HALF;
    s = t >>> COEFF_FRAC;
    if (s > OUT_MAX) begin
      s = OUT_MAX;
    end else if (s < OUT_MIN) begin
      s = OUT_MIN;
    end
    return s[OUT_BITS-1:0];
  endfunction

  always_comb begin
    low_nxt  = round_sat(TOTAL_BITS'(even_sum) + TOTAL_BITS'(odd_sum));
    high_nxt = round_sat(TOTAL_BITS'(even_sum) - TOTAL_BITS'(odd_sum));
  end

  // Advance both histories on every input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      even_hist_r <= '{default: '0};
      odd_hist_r  <= '{default: '0};
    end else if (in_accept) begin
      even_hist_r[0] <= in_first_sample;
      odd_hist_r[0]  <= in_second_sample;
      for (int i = 1; i < PHASE_DEPTH; i++) begin
        even_hist_r[i] <= even_hist_r[i-1];
        odd_hist_r[i]  <= odd_hist_r[i-1];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ok1) begin
        v1_r <= in_valid;
      end
      if (ok2) begin
        v2_r <= v1_r;
      end
      if (ok3) begin
        v3_r <= v2_r;
      end
      if (ok4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_low_band  = low_r;
  assign out_high_band = high_r;

  // Input stalls only when every stage holds an item that cannot move
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r))
    else $error("input stalled with a bubble in the pipe");

  // A stage that cannot advance keeps its item
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !ok4) |=> v3_r)
    else $error("stage 3 item lost under stall");

  // History head takes the newest samples after a transfer
  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (even_hist_r[0] == $past(in_first_sample)
                   && odd_hist_r[0] == $past(in_second_sample)))
    else $error("history did not advance on input transfer");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule

// ===== dv/qmf_two_band_analysis_tb.sv =====
`timescale 1ns / 100ps

module qmf_two_band_analysis_tb;
  import qmf_pkg::*;

  // Traffic shaping and run limits
  localparam int IDLE_PCT     = 29;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int TAIL_CYCLES  = 12;
  localparam int PRINT_LIMIT  = 40;

  // Rounding and clamp bounds of the band outputs
  localparam longint ROUND_HALF = longint'(1) << (COEFF_FRAC - 1);
  localparam longint OUT_MAX    = (longint'(1) << (OUT_BITS - 1)) - 1;
  localparam longint OUT_MIN    = -OUT_MAX - 1;

  // Half of the symmetric prototype, doubled, Q0.23; tap k equals tap 47-k
  localparam int PROTO_HALF [HALF_TAPS] = '{
    -245,     -1544,    -942,     5053,
    4064,     -14310,   -8734,    34125,
    13142,    -70722,   -12686,   131538,
    -1026,    -225513,  41317,    364671,
    -130890,  -571939,  315571,   911439,
    -731426,  -1667393, 2215919,  7788681
  };

  typedef struct packed {
    out_t low;
    out_t high;
  } band_pair_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_first_sample = '0;
  sample_t in_second_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  out_t    out_low_band;
  out_t    out_high_band;

  // Predictor state: past first and second samples, newest at index 0
  sample_t first_past [PHASE_DEPTH];
  sample_t second_past [PHASE_DEPTH];

  band_pair_t pending_bands [$];

  int in_idle_pct = IDLE_PCT;
  int out_stall_pct = IDLE_PCT;
  int cycle_count = 0;
  int error_count = 0;
  int pairs_in = 0;
  int bands_checked = 0;
  int matched_runs = 0;
  int saturated_seen = 0;

  qmf_two_band_analysis DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_sample  (in_first_sample),
    .in_second_sample (in_second_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_low_band     (out_low_band),
    .out_high_band    (out_high_band)
  );

  always #1 clk = ~clk;

  // Coefficient of prototype tap k, folded onto the stored half
  function automatic longint proto_tap(input int k);
    return (k < HALF_TAPS) ? longint'(PROTO_HALF[k]) : longint'(PROTO_HALF[TAP_COUNT - 1 - k]);
  endfunction

  // Round half up from Q.23 products to sample scale, then clamp to 17 bits
  function automatic out_t round_clamp(input longint acc);
    longint r;
    r = (acc + ROUND_HALF) >>> COEFF_FRAC;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < OUT_MIN) begin
      r = OUT_MIN;
    end
    return out_t'(r);
  endfunction

  // Filter one sample pair: form both phase sums over the current pair and the
  // histories, advance the histories, return the low and high band.
  function automatic band_pair_t filter_pair(input sample_t first_s, input sample_t second_s);
    longint even_acc;
    longint odd_acc;
    band_pair_t bands;
    even_acc = proto_tap(0) * longint'(second_s);
    odd_acc  = proto_tap(1) * longint'(first_s);
    for (int i = 1; i < PHASE_TAPS; i++) begin
      even_acc += proto_tap(2 * i) * longint'(second_past[i - 1]);
      odd_acc  += proto_tap(2 * i + 1) * longint'(first_past[i - 1]);
    end
    for (int i = PHASE_DEPTH - 1; i > 0; i--) begin
      first_past[i]  = first_past[i - 1];
      second_past[i] = second_past[i - 1];
    end
    first_past[0]  = first_s;
    second_past[0] = second_s;
    bands.low  = round_clamp(even_acc + odd_acc);
    bands.high = round_clamp(even_acc - odd_acc);
    return bands;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_bands.size());
      $display("qmf_two_band_analysis_tb: errors");
      $finish;
    end
  end

  // Result side: stall at random, a fresh decision every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Monitor both channels at the edge. Predict on every input transfer first,
  // then compare any result transfer against the oldest pending prediction.
  always @(posedge clk) begin
    band_pair_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_bands.push_back(filter_pair(in_first_sample, in_second_sample));
        pairs_in++;
      end
      if (out_valid && !out_stall) begin
        if (pending_bands.size() == 0) begin
          report_mismatch($sformatf("result low=%0d high=%0d with nothing pending",
                                    out_low_band, out_high_band));
        end else begin
          want = pending_bands.pop_front();
          if (out_low_band !== want.low) begin
            report_mismatch($sformatf("low band got %0d expected %0d",
                                      out_low_band, want.low));
          end
          if (out_high_band !== want.high) begin
            report_mismatch($sformatf("high band got %0d expected %0d",
                                      out_high_band, want.high));
          end
          if (want.low == out_t'(OUT_MAX) || want.low == out_t'(OUT_MIN) ||
              want.high == out_t'(OUT_MAX) || want.high == out_t'(OUT_MIN)) begin
            saturated_seen++;
          end
          bands_checked++;
        end
      end
    end
  end

  // Send one pair: idle at random first, then hold valid and payload steady
  // until the edge that takes the transfer.
  task automatic send_pair(input sample_t first_s, input sample_t second_s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_first_sample  <= first_s;
    in_second_sample <= second_s;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted result has come back; step the
  // clock first so the monitor has logged the last transfer.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bands.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Large magnitude of the requested sign
  function automatic sample_t signed_mag(input bit negative, input int mag_min);
    if (negative) begin
      return sample_t'(-int'($urandom_range(32768, mag_min)));
    end
    return sample_t'($urandom_range(32767, mag_min));
  endfunction

  // Send pairs whose signs follow the taps they will meet at the last pair, so
  // the chosen band piles up toward its clamp. The high band takes the odd
  // phase with a minus sign, so flip the first samples for it.
  task automatic send_matched_run(input bit hit_high, input bit negative, input int mag_min,
                                  input int oldest_age);
    bit first_neg;
    bit second_neg;
    for (int age = oldest_age; age >= 0; age--) begin
      second_neg = (proto_tap(2 * age) < 0) ^ negative;
      first_neg  = (proto_tap(2 * age + 1) < 0) ^ negative ^ hit_high;
      send_pair(signed_mag(first_neg, mag_min), signed_mag(second_neg, mag_min));
    end
    matched_runs++;
  endtask

  // Corners of both fields against a zero past
  task automatic test_extremes();
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'shffff, 16'sh0001);
  endtask

  // Drive the low band into its upper clamp; the oldest taps are tiny, so
  // start the run four ages short of the full window.
  task automatic test_saturation();
    send_matched_run(1'b0, 1'b0, 32767, 19);
  endtask

  // Mixed traffic: mostly full-range pairs, some near zero to work the
  // rounding, and bursts of matched runs that reach both clamps of both bands.
  task automatic test_random_traffic(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_matched_run(1'($urandom_range(1)), 1'($urandom_range(1)),
                         $urandom_range(32767, 12000), PHASE_DEPTH);
        sent += PHASE_TAPS;
      end else if (pick < 30) begin
        send_pair(sample_t'(int'($urandom_range(31)) - 16),
                  sample_t'(int'($urandom_range(31)) - 16));
        sent++;
      end else begin
        send_pair(sample_t'($urandom), sample_t'($urandom));
        sent++;
      end
    end
  endtask

  // Pause the sender until the pipe is empty, then resume from a cold pipe
  task automatic test_drained_pause();
    test_random_traffic(40);
    wait_for_results();
    test_random_traffic(40);
  endtask

  // Back-to-back transfers with no idling on either side
  task automatic test_full_rate(input int count);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    test_random_traffic(count);
    in_idle_pct   = IDLE_PCT;
    out_stall_pct = IDLE_PCT;
  endtask

  initial begin
    for (int i = 0; i < PHASE_DEPTH; i++) begin
      first_past[i]  = '0;
      second_past[i] = '0;
    end

    // Hold reset, then release it once
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_saturation();
    test_random_traffic(260);
    test_drained_pause();
    test_full_rate(150);
    test_random_traffic(170);

    // Drain, then let the pipe run on empty to catch stray results
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_bands.size() != 0) begin
      report_mismatch($sformatf("%0d results never came back", pending_bands.size()));
    end

    $display("sent %0d sample pairs, checked %0d band pairs (%0d at a clamp)",
             pairs_in, bands_checked, saturated_seen);
    $display("included %0d matched runs, one drained pause and one full-rate stretch",
             matched_runs);
    if (error_count == 0) begin
      $display("qmf_two_band_analysis_tb: clean");
    end else begin
      $display("qmf_two_band_analysis_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/qmf_pkg.sv
design/qmf_phase_sum.sv
design/qmf_two_band_analysis.sv
dv/qmf_two_band_analysis_tb.sv
